// ===== src/wcs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the windowed counter cluster select block.
// Types, constants and codes shared by the top level and the testbench.

package wcs_pkg;

  localparam int MAX_CLUSTERS = 64;
  localparam int WINDOW       = 8;
  localparam int MAX_CPN      = 16;
  localparam int MASK_BITS    = 16;
  localparam int COUNT_BITS   = 48;

  // Scan length bound: min(MAX_CPN, MASK_BITS)
  localparam int MAX_SCAN = (MAX_CPN < MASK_BITS) ? MAX_CPN : MASK_BITS;

  localparam int CL_W     = 6;                       // cluster_index / cluster_id
  localparam int NODE_W   = 4;
  localparam int CFG_W    = 5;
  localparam int WIN_W    = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int SUM_W    = COUNT_BITS + WIN_W;
  localparam int K_W      = $clog2(MAX_SCAN + 1);
  localparam int BASE_W   = CFG_W + NODE_W;
  localparam int G_W      = BASE_W + 1;
  localparam int STORE_DEPTH = MAX_CLUSTERS * WINDOW;

  // Input tdata layout, lowest bit first
  localparam int IN_CL_LO    = 0;
  localparam int IN_CNT_LO   = IN_CL_LO + CL_W;
  localparam int IN_NODE_LO  = IN_CNT_LO + COUNT_BITS;
  localparam int IN_MASK_LO  = IN_NODE_LO + NODE_W;
  localparam int IN_BITS     = IN_MASK_LO + MASK_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = ((CL_W + STATUS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CPN   = 1'd0,
    REG_NODES = 1'd1
  } cfg_reg_e;

  typedef enum logic {
    FUNC_PUSH   = 1'b0,
    FUNC_SELECT = 1'b1
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND    = 2'd0,
    STAT_BAD_NODE = 2'd1,
    STAT_NO_FREE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_S_META,
    ST_S_OLD,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Per-cluster window bookkeeping, one word of the meta memory
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [WIN_W-1:0]  head;
    logic [FILL_W-1:0] fill;
  } meta_t;

  localparam int META_W = $bits(meta_t);

endpackage

// ===== src/wcs_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.

module wcs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/windowed_counter_cluster_select_top.sv =====
`timescale 1ns / 1ps
// Sample: meta read, then, once the window is full, a store read of the oldest count,
// then write back; a sample has no result.
// Select over n clusters (n <= 16): scan reads in ST_SCAN, ST_DRAIN, then the result loads
// in ST_FINISH once the output is free; no new request until then. Bad node goes to ST_FINISH.
// Reset (async, active low) clears control and per-cluster valid bits, sets config to defaults;
// the count store stays undefined until written, no clearing pass. Uses wcs_pkg and wcs_ram.

module windowed_counter_cluster_select_top
  import wcs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // cluster_index, count, node, used_mask; zero padded
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [0:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // cluster_id, status; zero padded
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int META_AW  = $clog2(MAX_CLUSTERS);

  // Configuration
  logic [CFG_W-1:0] cpn_q, nodes_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpn_q   <= CFG_W'(4);
      nodes_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CPN:   cpn_q   <= cfg_data_i;
        REG_NODES: nodes_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // Input fields
  logic                  in_func;
  logic [CL_W-1:0]       in_cluster;
  logic [COUNT_BITS-1:0] in_count;
  logic [NODE_W-1:0]     in_node;
  logic [MASK_BITS-1:0]  in_mask;
  logic                  in_accept;
  logic                  in_bad;

  assign in_func    = s_axis_tuser[0];
  assign in_cluster = s_axis_tdata[IN_CL_LO +: CL_W];
  assign in_count   = s_axis_tdata[IN_CNT_LO +: COUNT_BITS];
  assign in_node    = s_axis_tdata[IN_NODE_LO +: NODE_W];
  assign in_mask    = s_axis_tdata[IN_MASK_LO +: MASK_BITS];
  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign in_bad     = {1'b0, in_node} >= nodes_q;

  // State
  state_e state_q, state_d;

  logic [CL_W-1:0]       cl_q, cl_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  meta_t                 meta_q, meta_d;
  logic                  bad_q, bad_d;
  logic [K_W-1:0]        n_q, n_d, k_q, k_d;
  logic [BASE_W-1:0]     base_q, base_d;
  logic [MASK_BITS-1:0]  used_q, used_d;
  logic                  found_q, found_d;
  logic [SUM_W-1:0]      best_sum_q, best_sum_d;
  logic [CL_W-1:0]       best_id_q, best_id_d;
  logic                  pipe_vld_q, pipe_vld_d;
  logic [CL_W-1:0]       pipe_id_q, pipe_id_d;
  logic                  vld_rd_q, vld_rd_d;
  logic [MAX_CLUSTERS-1:0] valid_q;
  logic                  m_vld_q, m_vld_d;
  logic [CL_W-1:0]       out_id_q, out_id_d;
  status_e               out_status_q, out_status_d;

  // Memory ports
  logic                  store_we, store_re;
  logic [STORE_AW-1:0]   store_waddr, store_raddr;
  logic [COUNT_BITS-1:0] store_wdata, store_rdata;
  logic                  meta_we, meta_re;
  logic [META_AW-1:0]    meta_waddr, meta_raddr;
  meta_t                 meta_wdata, meta_rdata;
  meta_t                 meta_eff;

  wcs_ram #(.DEPTH(STORE_DEPTH), .WIDTH(COUNT_BITS)) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  wcs_ram #(.DEPTH(MAX_CLUSTERS), .WIDTH(META_W)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // A cluster never written reads as empty
  assign meta_eff = vld_rd_q ? meta_rdata : '0;

  logic            win_full;
  logic [G_W-1:0]  scan_g;
  logic            scan_issue;
  logic            out_free;

  assign win_full   = meta_eff.fill >= FILL_W'(WINDOW);
  assign scan_g     = G_W'(base_q) + G_W'(k_q);
  assign scan_issue = (k_q < n_q) && (scan_g < G_W'(MAX_CLUSTERS));
  assign out_free   = !m_vld_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (func_e'(in_func) == FUNC_PUSH) begin
            state_d = ST_S_META;
          end else if (in_bad) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_S_META: state_d = win_full ? ST_S_OLD : ST_IDLE;
      ST_S_OLD:  state_d = ST_IDLE;
      ST_SCAN: begin
        if (!scan_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cl_d         = cl_q;
    cnt_d        = cnt_q;
    meta_d       = meta_q;
    bad_d        = bad_q;
    n_d          = n_q;
    k_d          = k_q;
    base_d       = base_q;
    used_d       = used_q;
    found_d      = found_q;
    best_sum_d   = best_sum_q;
    best_id_d    = best_id_q;
    pipe_vld_d   = 1'b0;
    pipe_id_d    = pipe_id_q;
    vld_rd_d     = vld_rd_q;
    out_id_d     = out_id_q;
    out_status_d = out_status_q;
    m_vld_d      = m_vld_q && !m_axis_tready;

    store_we    = 1'b0;
    store_waddr = {cl_q, meta_eff.head + meta_eff.fill[WIN_W-1:0]};
    store_wdata = cnt_q;
    store_re    = 1'b0;
    store_raddr = {cl_q, meta_eff.head};
    meta_we     = 1'b0;
    meta_waddr  = cl_q;
    meta_wdata  = meta_eff;
    meta_re     = 1'b0;
    meta_raddr  = in_cluster;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (func_e'(in_func) == FUNC_PUSH) begin
            meta_re  = 1'b1;
            vld_rd_d = valid_q[in_cluster];
            cl_d     = in_cluster;
            cnt_d    = in_count;
          end else begin
            bad_d   = in_bad;
            n_d     = (cpn_q > CFG_W'(MAX_SCAN)) ? K_W'(MAX_SCAN) : K_W'(cpn_q);
            base_d  = BASE_W'(cpn_q * in_node);
            used_d  = in_mask;
            k_d     = '0;
            found_d = 1'b0;
          end
        end
      end
      ST_S_META: begin
        meta_d = meta_eff;
        if (!win_full) begin
          store_we        = 1'b1;
          meta_we         = 1'b1;
          meta_wdata.sum  = meta_eff.sum + SUM_W'(cnt_q);
          meta_wdata.fill = meta_eff.fill + FILL_W'(1);
        end else begin
          store_re = 1'b1;
        end
      end
      ST_S_OLD: begin
        // Full window: drop the oldest count, put the new one in its slot
        store_we        = 1'b1;
        store_waddr     = {cl_q, meta_q.head};
        meta_we         = 1'b1;
        meta_wdata      = meta_q;
        meta_wdata.sum  = meta_q.sum - SUM_W'(store_rdata) + SUM_W'(cnt_q);
        meta_wdata.head = meta_q.head + WIN_W'(1);
      end
      ST_SCAN, ST_DRAIN: begin
        if (state_q == ST_SCAN && scan_issue) begin
          meta_re    = 1'b1;
          meta_raddr = scan_g[META_AW-1:0];
          vld_rd_d   = valid_q[scan_g[META_AW-1:0]];
          pipe_vld_d = !used_q[k_q[$clog2(MASK_BITS)-1:0]];
          pipe_id_d  = scan_g[CL_W-1:0];
          k_d        = k_q + K_W'(1);
        end
        // Compare the sum read last cycle; strict less keeps the lowest index
        if (pipe_vld_q && (!found_q || meta_eff.sum < best_sum_q)) begin
          found_d    = 1'b1;
          best_sum_d = meta_eff.sum;
          best_id_d  = pipe_id_q;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_vld_d = 1'b1;
          if (bad_q) begin
            out_status_d = STAT_BAD_NODE;
            out_id_d     = '0;
          end else if (found_q) begin
            out_status_d = STAT_FOUND;
            out_id_d     = best_id_q;
          end else begin
            out_status_d = STAT_NO_FREE;
            out_id_d     = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      m_vld_q    <= 1'b0;
      pipe_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      m_vld_q    <= m_vld_d;
      pipe_vld_q <= pipe_vld_d;
      if (meta_we) begin
        valid_q[meta_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q         <= cl_d;
    cnt_q        <= cnt_d;
    meta_q       <= meta_d;
    bad_q        <= bad_d;
    n_q          <= n_d;
    k_q          <= k_d;
    base_q       <= base_d;
    used_q       <= used_d;
    found_q      <= found_d;
    best_sum_q   <= best_sum_d;
    best_id_q    <= best_id_d;
    pipe_id_q    <= pipe_id_d;
    vld_rd_q     <= vld_rd_d;
    out_id_q     <= out_id_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_status_q, out_id_q});

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> k_q <= K_W'(MAX_SCAN))
    else $error("scan ran past its bound");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_vld_q && out_status_q != STAT_FOUND |-> out_id_q == '0)
    else $error("cluster id not zero on a failed select");

  a_store_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == ST_S_META || state_q == ST_S_OLD))
    else $error("store written outside a sample");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH && out_free |=> m_vld_q && state_q == ST_IDLE)
    else $error("select result not loaded");

  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_we |=> valid_q[$past(meta_waddr)])
    else $error("meta entry written but not marked valid");
`endif

endmodule

// ===== tb/sv/tb_windowed_counter_cluster_select_top.sv =====
`timescale 1ns / 1ps
// Testbench for windowed_counter_cluster_select_top: pushes event-count samples and
// idle-cluster selects across several node layouts, checks each select result.
// Depends on wcs_pkg and the block's RTL only.

module tb_windowed_counter_cluster_select_top
  import wcs_pkg::*;
;

  localparam int DRAIN_CYCLES    = 25;   // margin past the longest select
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 64;
  localparam int PHASES          = 9;

  typedef struct {
    logic [CL_W-1:0] cluster_id;
    status_e         status;
  } pick_t;

  // Tracks per-cluster windows and predicts the cluster each select returns.
  class cluster_pick_board;
    logic [COUNT_BITS-1:0] slot [MAX_CLUSTERS][WINDOW];
    int unsigned           fill [MAX_CLUSTERS];
    int unsigned           head [MAX_CLUSTERS];
    logic [63:0]           load_sum [MAX_CLUSTERS];
    logic [CFG_W-1:0]      cpn;
    logic [CFG_W-1:0]      nodes;
    pick_t                 picks_due [$];
    int                    errors;

    function new();
      foreach (fill[c]) begin
        fill[c]     = 0;
        head[c]     = 0;
        load_sum[c] = '0;
      end
      cpn    = 5'd4;
      nodes  = 5'd1;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      if (idx == REG_CPN) cpn = val;
      else nodes = val;
    endfunction

    function void push_count(int unsigned c, logic [COUNT_BITS-1:0] cnt);
      int unsigned pos;
      if (fill[c] < WINDOW) begin
        pos = (head[c] + fill[c]) % WINDOW;
        slot[c][pos] = cnt;
        fill[c]++;
        load_sum[c] = load_sum[c] + cnt;
      end else begin
        // full window: oldest count drops out
        pos = head[c];
        load_sum[c] = load_sum[c] - slot[c][pos] + cnt;
        slot[c][pos] = cnt;
        head[c] = (pos + 1) % WINDOW;
      end
    endfunction

    function void pick_cluster(logic [NODE_W-1:0] node, logic [MASK_BITS-1:0] used);
      pick_t       p;
      int unsigned n;
      int unsigned base;
      int unsigned g;
      logic [63:0] low;
      bit          hit;
      p.cluster_id = '0;
      p.status     = STAT_NO_FREE;
      hit = 1'b0;
      low = '0;
      if (node >= nodes) begin
        p.status = STAT_BAD_NODE;
      end else begin
        n = cpn;
        if (n > MAX_CPN) n = MAX_CPN;
        if (n > MASK_BITS) n = MASK_BITS;
        base = cpn * node;
        for (int k = 0; k < n; k++) begin
          g = base + k;
          if (g >= MAX_CLUSTERS) break;
          if (!used[k] && (!hit || load_sum[g] < low)) begin
            hit          = 1'b1;
            low          = load_sum[g];
            p.cluster_id = g[CL_W-1:0];
            p.status     = STAT_FOUND;
          end
        end
      end
      picks_due.insert(picks_due.size(), p);
    endfunction

    function void note_request(func_e f, logic [IN_TDATA_W-1:0] d);
      if (f == FUNC_PUSH) push_count(d[IN_CL_LO +: CL_W], d[IN_CNT_LO +: COUNT_BITS]);
      else pick_cluster(d[IN_NODE_LO +: NODE_W], d[IN_MASK_LO +: MASK_BITS]);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      pick_t             want;
      logic [CL_W-1:0]     got_id;
      logic [STATUS_W-1:0] got_st;
      got_id = d[CL_W-1:0];
      got_st = d[CL_W +: STATUS_W];
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual cluster_id %0d status %0d",
                 $time, got_id, got_st);
        errors++;
        return;
      end
      want = picks_due.pop_front();
      if (got_id !== want.cluster_id) begin
        $display("%0t: cluster_id mismatch: expected %0d, actual %0d",
                 $time, want.cluster_id, got_id);
        errors++;
      end
      if (got_st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got_st);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_W-1:0]       cfg_data_i;

  cluster_pick_board board = new();
  bit quiet = 1'b0;
  int stall_cycles = 0;

  windowed_counter_cluster_select_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // result side: random backpressure, check on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      m_axis_tready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_windowed_counter_cluster_select_top failed");
        $finish;
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pack_req(logic [CL_W-1:0] cl,
                                                      logic [COUNT_BITS-1:0] cnt,
                                                      logic [NODE_W-1:0] node,
                                                      logic [MASK_BITS-1:0] used);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[IN_CL_LO +: CL_W]         = cl;
    d[IN_CNT_LO +: COUNT_BITS]  = cnt;
    d[IN_NODE_LO +: NODE_W]     = node;
    d[IN_MASK_LO +: MASK_BITS]  = used;
    return d;
  endfunction

  function automatic logic [COUNT_BITS-1:0] rand_count();
    logic [63:0] w;
    int unsigned pick;
    w    = {$urandom, $urandom};
    pick = $urandom_range(99);
    // small counts make equal sums, so ties come up often
    if (pick < 30) w = 64'($urandom_range(7));
    else if (pick < 55) w = 64'($urandom);
    else if (pick < 65) w = '1;
    else if (pick < 70) w = '0;
    return w[COUNT_BITS-1:0];
  endfunction

  function automatic logic [MASK_BITS-1:0] rand_mask(int unsigned n);
    int unsigned pick;
    logic [MASK_BITS-1:0] m;
    pick = $urandom_range(99);
    m    = MASK_BITS'($urandom);
    if (n == 0 || n > MASK_BITS) n = MASK_BITS;
    if (pick < 20) m = '0;
    else if (pick < 40) m = ~(16'h1 << $urandom_range(n - 1));  // one free cluster
    else if (pick < 50) m = '1;
    else if (pick < 70) m = m & MASK_BITS'($urandom);
    return m;
  endfunction

  task automatic send_req(input func_e f, input logic [IN_TDATA_W-1:0] d);
    if (!quiet) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= f;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(f, d);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.picks_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_layout(input logic [CFG_W-1:0] cpn, input logic [CFG_W-1:0] nodes);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_CPN;
    cfg_data_i  <= cpn;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(REG_CPN, cpn);
    cfg_index_i <= REG_NODES;
    cfg_data_i  <= nodes;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(REG_NODES, nodes);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int unsigned span;
    int unsigned n;
    int unsigned node_top;
    logic [CL_W-1:0]   cl;
    logic [NODE_W-1:0] node;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(99) < 2) wait_drained();
      span = board.cpn * board.nodes;
      if (span == 0 || span > MAX_CLUSTERS) span = MAX_CLUSTERS;
      n = (board.cpn > MASK_BITS) ? MASK_BITS : board.cpn;
      node_top = (board.nodes > 16) ? 16 : board.nodes;
      if ($urandom_range(99) < 55) begin
        cl = ($urandom_range(99) < 75) ? CL_W'($urandom_range(span - 1)) :
                                         CL_W'($urandom_range(63));
        send_req(FUNC_PUSH, pack_req(cl, rand_count(), NODE_W'($urandom),
                                     MASK_BITS'($urandom)));
      end else begin
        node = (node_top > 0 && $urandom_range(99) < 85) ?
               NODE_W'($urandom_range(node_top - 1)) : NODE_W'($urandom_range(15));
        send_req(FUNC_SELECT, pack_req(CL_W'($urandom), COUNT_BITS'({$urandom, $urandom}),
                                       node, rand_mask(n)));
      end
    end
  endtask

  initial begin
    int cpn_list   [PHASES];
    int nodes_list [PHASES];
    cpn_list      = '{16, 1, 0, 31, 16, 7, 2, 5, 0};
    nodes_list    = '{4, 16, 3, 31, 0, 9, 16, 13, 0};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_PUSH;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_CPN;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset layout: four clusters on one node
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'h0000));   // all sums zero
    send_req(FUNC_PUSH, pack_req(6'd0, '1, '0, '0));
    send_req(FUNC_PUSH, pack_req(6'd1, 48'd5, '0, '0));
    send_req(FUNC_PUSH, pack_req(6'd2, 48'd5, '0, '0));
    send_req(FUNC_PUSH, pack_req(6'd3, 48'd0, '0, '0));
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'h0000));
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'h0008));   // tie, lower index
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'h000F));   // nothing free
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'hFFF0));   // bits past the node
    send_req(FUNC_SELECT, pack_req('1, '1, 4'd1, 16'h0000));   // bad node
    send_req(FUNC_SELECT, pack_req('1, '1, 4'd15, 16'hFFFF));
    // overfill cluster 2 with max counts so the window wraps
    for (int i = 0; i < 9; i++) send_req(FUNC_PUSH, pack_req(6'd2, '1, '1, '1));
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'h0009));
    send_req(FUNC_SELECT, pack_req('0, '0, 4'd0, 16'h000B));

    cpn_list[PHASES-1]   = $urandom_range(31);
    nodes_list[PHASES-1] = $urandom_range(31);
    for (int ph = 0; ph < PHASES; ph++) begin
      set_layout(CFG_W'(cpn_list[ph]), CFG_W'(nodes_list[ph]));
      quiet = (ph == 5);
      run_random(ITEMS_PER_PHASE);
    end
    quiet = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.picks_due.size() == 0) begin
      $display("tb_windowed_counter_cluster_select_top passed");
    end else begin
      $display("tb_windowed_counter_cluster_select_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wcs_pkg.sv
src/wcs_ram.sv
src/windowed_counter_cluster_select_top.sv
tb/sv/tb_windowed_counter_cluster_select_top.sv
